// ===== design/lbph_pkg.sv =====
// ----------------------------------------------------------------------------
// lbph_pkg
// shared constants and band edge helpers for the log band bar engine
// ----------------------------------------------------------------------------
package lbph_pkg;

    localparam int BAND_COUNT  = 32;
    localparam int BIN_COUNT   = 128;
    localparam int MAX_RESULTS = 8;

    localparam int BAND_W  = $clog2(BAND_COUNT);
    localparam int BIN_W   = $clog2(BIN_COUNT);
    localparam int MAG_W   = 23;
    localparam int H_W     = 16;
    localparam int GAIN_W  = 10;
    localparam int CFG_W   = 16;
    localparam int CIDX_W  = 2;
    localparam int CNT_W   = $clog2(MAX_RESULTS);
    localparam int MUL_W   = 32;
    localparam int PROD_W  = 2 * MUL_W;
    localparam int EDGE_W  = 8;
    localparam int Y_W     = 20;
    localparam int Z_W     = 31;
    localparam int LINT_W  = 2;
    localparam int LFRAC_W = 16;
    localparam int SQ_CNT_W = $clog2(LFRAC_W);
    localparam int ENTRY_W = 2 * H_W;

    // log10(2) in Q32
    localparam logic [MUL_W-1:0] LOG10_2_Q32 = 32'd1292913987;

    localparam logic [H_W-1:0] H_FULL = {H_W{1'b1}};

    // input item kinds
    localparam logic FUNC_BIN   = 1'b0;
    localparam logic FUNC_CLEAR = 1'b1;

    // configuration register indexes
    localparam logic [CIDX_W-1:0] CFG_GAIN       = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_BAR_DECAY  = 2'd1;
    localparam logic [CIDX_W-1:0] CFG_PEAK_DECAY = 2'd2;

    localparam logic [GAIN_W-1:0] GAIN_RST       = 10'd120;
    localparam logic [H_W-1:0]    BAR_DECAY_RST  = 16'd49152;
    localparam logic [H_W-1:0]    PEAK_DECAY_RST = 16'd60293;

    // log-spaced band edges, floor(2^(7*k/32))
    localparam logic [EDGE_W-1:0] EDGE_TAB [0:BAND_COUNT] = '{
        8'd1,  8'd1,  8'd1,  8'd1,  8'd1,  8'd2,  8'd2,  8'd2,  8'd3,
        8'd3,  8'd4,  8'd5,  8'd6,  8'd7,  8'd8,  8'd9,  8'd11,
        8'd13, 8'd15, 8'd17, 8'd20, 8'd24, 8'd28, 8'd32, 8'd38,
        8'd44, 8'd51, 8'd59, 8'd69, 8'd81, 8'd94, 8'd109, 8'd128
    };

    function automatic logic [BIN_W-1:0] band_lo(input logic [BAND_W-1:0] b);
        logic [EDGE_W-1:0] e;
        e = EDGE_TAB[b];
        if (e < EDGE_W'(1)) begin
            e = EDGE_W'(1);
        end
        return e[BIN_W-1:0];
    endfunction

    function automatic logic [BIN_W-1:0] band_hi(input logic [BAND_W-1:0] b);
        logic [BAND_W:0]    idx;
        logic [EDGE_W-1:0]  e;
        logic [BIN_W-1:0]   lo;
        logic [BIN_W-1:0]   hi;
        idx = {1'b0, b} + (BAND_W+1)'(1);
        e   = EDGE_TAB[idx];
        lo  = band_lo(b);
        if (e >= EDGE_W'(BIN_COUNT)) begin
            hi = BIN_W'(BIN_COUNT - 1);
        end else begin
            hi = e[BIN_W-1:0];
        end
        if (hi < lo) begin
            hi = lo;
        end
        return hi;
    endfunction

endpackage

// ===== design/lbph_ram.sv =====
// ----------------------------------------------------------------------------
// lbph_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module lbph_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [0:DEPTH-1];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== design/lbph_mul.sv =====
// ----------------------------------------------------------------------------
// lbph_mul
// shared unsigned multiplier with registered product
// ----------------------------------------------------------------------------
module lbph_mul (
    input  logic                       aclk,
    input  logic [lbph_pkg::MUL_W-1:0]  op_a,
    input  logic [lbph_pkg::MUL_W-1:0]  op_b,
    output logic [lbph_pkg::PROD_W-1:0] prod
);
    import lbph_pkg::*;

    logic [PROD_W-1:0] prod_reg;

    always_ff @(posedge aclk) begin
        prod_reg <= PROD_W'(op_a) * PROD_W'(op_b);
    end

    assign prod = prod_reg;

endmodule

// ===== design/log_band_peak_hold_bars.sv =====
// ----------------------------------------------------------------------------
// log_band_peak_hold_bars
// spectrum bar engine: groups fft bin magnitudes into log-spaced bands and
// keeps a decaying bar height and a peak hold marker per band
// ----------------------------------------------------------------------------
// a bin that completes no band is checked and returns to idle; a clear
//   transaction is taken in idle; a bin that completes n bands (up to 8)
//   goes through the band steps n times, plus any wait for the output slot
// the band cost is set by the one shared multiplier: gain product, 16 squaring
//   passes of the log mantissa, log10 scaling, two decays; a saturated log
//   skips the squaring passes and the scaling
// no new transaction is accepted until the block is back in idle
// reset: synchronous active low; heights read as zero, registers at defaults
// ----------------------------------------------------------------------------
module log_band_peak_hold_bars (
    input  logic                          aclk,
    input  logic                          aresetn,
    // bin transactions
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_func,
    input  logic [lbph_pkg::BIN_W-1:0]    s_bin,
    input  logic [lbph_pkg::MAG_W-1:0]    s_magnitude,
    // band result transactions
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [lbph_pkg::BAND_W-1:0]   m_band,
    output logic [lbph_pkg::H_W-1:0]      m_bar_height,
    output logic [lbph_pkg::H_W-1:0]      m_peak_height,
    output logic                          m_last,
    // configuration writes
    input  logic                          cfg_we,
    input  logic [lbph_pkg::CIDX_W-1:0]   cfg_index,
    input  logic [lbph_pkg::CFG_W-1:0]    cfg_data
);
    import lbph_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,      // compare bin with the open band
        ST_GAIN_MUL,   // gain * running max
        ST_LOG_INIT,   // saturation test, normalize mantissa
        ST_SQ_MUL,     // square the mantissa
        ST_SQ_FIX,     // take one fraction bit, renormalize
        ST_SCALE_MUL,  // log2 -> log10
        ST_SCALE_FIX,
        ST_BAR_MUL,
        ST_BAR_FIX,
        ST_PEAK_MUL,
        ST_PEAK_FIX,
        ST_EMIT        // wait for the output slot, write back
    } state_t;

    state_t state_reg;

    // configuration
    logic [GAIN_W-1:0] gain_reg;
    logic [H_W-1:0]    bar_decay_reg;
    logic [H_W-1:0]    peak_decay_reg;

    // band tracking
    logic [MAG_W-1:0]      running_max_reg;
    logic [BAND_W-1:0]     next_band_reg;
    logic [BAND_COUNT-1:0] valid_reg;     // cleared entries read as zero
    logic [CNT_W-1:0]      count_reg;     // results produced for this bin
    logic [BIN_W-1:0]      bin_reg;
    logic [MAG_W-1:0]      mag_reg;

    // log datapath
    logic [Z_W-1:0]      z_reg;
    logic [LINT_W-1:0]   lint_reg;
    logic [LFRAC_W-1:0]  lfrac_reg;
    logic [SQ_CNT_W-1:0] sq_cnt_reg;
    logic [H_W-1:0]      norm_reg;
    logic [H_W-1:0]      bar_new_reg;
    logic [H_W-1:0]      peak_new_reg;

    // output register
    logic              m_valid_reg;
    logic [BAND_W-1:0] m_band_reg;
    logic [H_W-1:0]    m_bar_reg;
    logic [H_W-1:0]    m_peak_reg;
    logic              m_last_reg;

    // shared multiplier
    logic [MUL_W-1:0]  mul_a;
    logic [MUL_W-1:0]  mul_b;
    logic [PROD_W-1:0] prod;

    // height store, bar in the upper half, peak in the lower
    logic [ENTRY_W-1:0] rd_data;
    logic               ram_rd_en;
    logic               ram_wr_en;

    // combinational helpers
    logic [BIN_W-1:0]  lo;
    logic [BIN_W-1:0]  hi;
    logic [BIN_W-1:0]  lo_following;
    logic [BIN_W-1:0]  hi_following;
    logic [BAND_W-1:0] band_following;
    logic              slot_free;
    logic              emit_last;
    logic [H_W-1:0]    old_bar;
    logic [H_W-1:0]    old_peak;
    logic              log_sat;
    logic [H_W-1:0]    t16;
    logic [Y_W-1:0]    y;
    logic [LINT_W-1:0] y_int;
    logic [Z_W-1:0]    z0;
    logic [MUL_W-1:0]  zs;
    logic [MUL_W-1:0]  scaled;

    assign lo             = band_lo(next_band_reg);
    assign hi             = band_hi(next_band_reg);
    assign band_following = next_band_reg + BAND_W'(1);
    assign lo_following   = band_lo(band_following);
    assign hi_following   = band_hi(band_following);

    assign slot_free = !m_valid_reg || m_ready;

    // this is the final result when the frame ends, the result budget runs
    // out, or the bin does not reach the end of the following band
    assign emit_last = (next_band_reg == BAND_W'(BAND_COUNT - 1))
                    || (count_reg == CNT_W'(MAX_RESULTS - 1))
                    || (bin_reg < hi_following);

    assign old_bar  = valid_reg[next_band_reg] ? rd_data[ENTRY_W-1:H_W] : '0;
    assign old_peak = valid_reg[next_band_reg] ? rd_data[H_W-1:0]       : '0;

    // log mantissa setup: y = 1 + 9t in Q16, normalized into Q30
    assign log_sat = |prod[PROD_W-1:H_W];
    assign t16     = prod[H_W-1:0];
    assign y       = {4'b0001, 16'h0000} + {1'b0, t16, 3'b000} + {4'b0000, t16};

    always_comb begin
        priority if (y[Y_W-1]) begin
            y_int = 2'd3;
        end else if (y[Y_W-2]) begin
            y_int = 2'd2;
        end else if (y[Y_W-3]) begin
            y_int = 2'd1;
        end else begin
            y_int = 2'd0;
        end
    end

    assign z0     = Z_W'({{(Z_W-Y_W){1'b0}}, y} << (4'd14 - {2'b00, y_int}));
    assign zs     = prod[MUL_W+29:30];
    assign scaled = prod[PROD_W-1:MUL_W];

    // operand select for the shared multiplier
    always_comb begin
        unique case (state_reg)
            ST_GAIN_MUL: begin
                mul_a = MUL_W'(gain_reg);
                mul_b = MUL_W'(running_max_reg);
            end
            ST_SQ_MUL: begin
                mul_a = MUL_W'(z_reg);
                mul_b = MUL_W'(z_reg);
            end
            ST_SCALE_MUL: begin
                mul_a = MUL_W'({lint_reg, lfrac_reg});
                mul_b = LOG10_2_Q32;
            end
            ST_BAR_MUL: begin
                mul_a = MUL_W'(old_bar);
                mul_b = MUL_W'(bar_decay_reg);
            end
            ST_PEAK_MUL: begin
                mul_a = MUL_W'(old_peak);
                mul_b = MUL_W'(peak_decay_reg);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    lbph_mul u_mul (
        .aclk (aclk),
        .op_a (mul_a),
        .op_b (mul_b),
        .prod (prod)
    );

    // read the open band's heights when it is about to complete
    assign ram_rd_en = (state_reg == ST_CHECK) && (bin_reg >= lo) && (bin_reg >= hi);
    assign ram_wr_en = (state_reg == ST_EMIT) && slot_free;

    lbph_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (BAND_COUNT)
    ) u_heights (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (next_band_reg),
        .wr_data ({bar_new_reg, peak_new_reg}),
        .rd_en   (ram_rd_en),
        .rd_addr (next_band_reg),
        .rd_data (rd_data)
    );

    // configuration registers, writes beyond the list are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_reg       <= GAIN_RST;
            bar_decay_reg  <= BAR_DECAY_RST;
            peak_decay_reg <= PEAK_DECAY_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_GAIN:       gain_reg       <= cfg_data[GAIN_W-1:0];
                CFG_BAR_DECAY:  bar_decay_reg  <= cfg_data[H_W-1:0];
                CFG_PEAK_DECAY: peak_decay_reg <= cfg_data[H_W-1:0];
                default: ;
            endcase
        end
    end

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            running_max_reg <= '0;
            next_band_reg   <= '0;
            valid_reg       <= '0;
            count_reg       <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            // result taken downstream
            if (m_valid_reg && m_ready && !ram_wr_en) begin
                m_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        if (s_func == FUNC_CLEAR) begin
                            valid_reg <= '0;
                        end else begin
                            bin_reg   <= s_bin;
                            mag_reg   <= s_magnitude;
                            count_reg <= '0;
                            state_reg <= ST_CHECK;
                        end
                    end
                end

                ST_CHECK: begin
                    if (bin_reg < lo) begin
                        state_reg <= ST_IDLE;
                    end else begin
                        if (bin_reg <= hi && mag_reg > running_max_reg) begin
                            running_max_reg <= mag_reg;
                        end
                        if (bin_reg < hi) begin
                            state_reg <= ST_IDLE;
                        end else begin
                            state_reg <= ST_GAIN_MUL;
                        end
                    end
                end

                ST_GAIN_MUL: begin
                    state_reg <= ST_LOG_INIT;
                end

                ST_LOG_INIT: begin
                    if (log_sat) begin
                        norm_reg  <= H_FULL;
                        state_reg <= ST_BAR_MUL;
                    end else begin
                        z_reg      <= z0;
                        lint_reg   <= y_int;
                        lfrac_reg  <= '0;
                        sq_cnt_reg <= '0;
                        state_reg  <= ST_SQ_MUL;
                    end
                end

                ST_SQ_MUL: begin
                    state_reg <= ST_SQ_FIX;
                end

                ST_SQ_FIX: begin
                    // square reached two or more: fraction bit set, halve
                    if (zs[MUL_W-1]) begin
                        z_reg <= zs[MUL_W-1:1];
                    end else begin
                        z_reg <= zs[Z_W-1:0];
                    end
                    lfrac_reg  <= {lfrac_reg[LFRAC_W-2:0], zs[MUL_W-1]};
                    sq_cnt_reg <= sq_cnt_reg + SQ_CNT_W'(1);
                    if (sq_cnt_reg == SQ_CNT_W'(LFRAC_W - 1)) begin
                        state_reg <= ST_SCALE_MUL;
                    end else begin
                        state_reg <= ST_SQ_MUL;
                    end
                end

                ST_SCALE_MUL: begin
                    state_reg <= ST_SCALE_FIX;
                end

                ST_SCALE_FIX: begin
                    if (|scaled[MUL_W-1:H_W]) begin
                        norm_reg <= H_FULL;
                    end else begin
                        norm_reg <= scaled[H_W-1:0];
                    end
                    state_reg <= ST_BAR_MUL;
                end

                ST_BAR_MUL: begin
                    state_reg <= ST_BAR_FIX;
                end

                ST_BAR_FIX: begin
                    // rise at once, else decay
                    if (norm_reg > old_bar) begin
                        bar_new_reg <= norm_reg;
                    end else begin
                        bar_new_reg <= prod[2*H_W-1:H_W];
                    end
                    state_reg <= ST_PEAK_MUL;
                end

                ST_PEAK_MUL: begin
                    state_reg <= ST_PEAK_FIX;
                end

                ST_PEAK_FIX: begin
                    // follow the bar, else decay
                    if (bar_new_reg > old_peak) begin
                        peak_new_reg <= bar_new_reg;
                    end else begin
                        peak_new_reg <= prod[2*H_W-1:H_W];
                    end
                    state_reg <= ST_EMIT;
                end

                ST_EMIT: begin
                    if (slot_free) begin
                        m_valid_reg     <= 1'b1;
                        m_band_reg      <= next_band_reg;
                        m_bar_reg       <= bar_new_reg;
                        m_peak_reg      <= peak_new_reg;
                        m_last_reg      <= emit_last;
                        valid_reg[next_band_reg] <= 1'b1;
                        if (emit_last && next_band_reg != BAND_W'(BAND_COUNT - 1)
                                && count_reg != CNT_W'(MAX_RESULTS - 1)
                                && bin_reg >= lo_following) begin
                            // shared edge bin also opens the following band
                            running_max_reg <= mag_reg;
                        end else begin
                            running_max_reg <= '0;
                        end
                        next_band_reg   <= band_following;
                        count_reg       <= count_reg + CNT_W'(1);
                        if (emit_last) begin
                            state_reg <= ST_IDLE;
                        end else begin
                            state_reg <= ST_CHECK;
                        end
                    end
                end

                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_ready       = (state_reg == ST_IDLE);
    assign m_valid       = m_valid_reg;
    assign m_band        = m_band_reg;
    assign m_bar_height  = m_bar_reg;
    assign m_peak_height = m_peak_reg;
    assign m_last        = m_last_reg;

endmodule

// ===== tb/lbph_band_checker.sv =====
// ----------------------------------------------------------------------------
// lbph_band_checker
// watches the bin and band result channels of the log band bar engine, keeps
// its own model of the band heights and compares every band result in order
// ----------------------------------------------------------------------------
module lbph_band_checker
    import lbph_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    input  logic              s_ready,
    input  logic              s_func,
    input  logic [BIN_W-1:0]  s_bin,
    input  logic [MAG_W-1:0]  s_magnitude,
    input  logic              m_valid,
    input  logic              m_ready,
    input  logic [BAND_W-1:0] m_band,
    input  logic [H_W-1:0]    m_bar_height,
    input  logic [H_W-1:0]    m_peak_height,
    input  logic              m_last,
    input  logic              cfg_we,
    input  logic [CIDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]  cfg_data,
    output int                mismatch_count,
    output int                pending_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PRINT_CAP = 200;

    typedef struct packed {
        logic [BAND_W-1:0] band;
        logic [H_W-1:0]    bar;
        logic [H_W-1:0]    peak;
        logic              last;
    } band_heights_t;

    band_heights_t     heights_due [$];
    logic [H_W-1:0]    bar_mem  [BAND_COUNT];
    logic [H_W-1:0]    peak_mem [BAND_COUNT];
    logic [MAG_W-1:0]  band_max;
    int                open_band;
    logic [GAIN_W-1:0] gain_q;
    logic [H_W-1:0]    bar_decay_q;
    logic [H_W-1:0]    peak_decay_q;
    int                fail_tally = 0;
    int                due_count  = 0;

    assign mismatch_count = fail_tally;
    assign pending_count  = due_count;

    function automatic int band_first_bin(input int b);
        int e;
        e = EDGE_TAB[b];
        if (e < 1) e = 1;
        return e;
    endfunction

    function automatic int band_final_bin(input int b);
        int e;
        int lo;
        e  = EDGE_TAB[b + 1];
        lo = band_first_bin(b);
        if (e > BIN_COUNT - 1) e = BIN_COUNT - 1;
        if (e < lo) e = lo;
        return e;
    endfunction

    // log10(1 + 9*t/65536) in q0.16 via log2 by mantissa squaring
    function automatic logic [H_W-1:0] log_height(input logic [63:0] t);
        logic [63:0] y;
        logic [63:0] z;
        logic [63:0] l;
        logic [63:0] r;
        int          p;
        int          i;
        if (t >= 64'd65536) return H_FULL;
        y = 64'd65536 + 64'd9 * t;
        p = 16;
        while (p < 40 && (y >> (p + 1)) != 64'd0) p++;
        z = y << (30 - p);
        l = 64'(p - 16) << 16;
        for (i = 15; i >= 0; i--) begin
            z = (z * z) >> 30;
            if (z >= (64'd1 << 31)) begin
                z    = z >> 1;
                l[i] = 1'b1;
            end
        end
        r = (l * 64'(LOG10_2_Q32)) >> 32;
        if (r > 64'd65535) r = 64'd65535;
        return r[H_W-1:0];
    endfunction

    task automatic report_mismatch(input string msg);
        if (fail_tally < PRINT_CAP) $display("mismatch at %0t: %s", $realtime, msg);
        fail_tally++;
    endtask

    task automatic advance_bands(input logic func, input logic [BIN_W-1:0] bin,
                                 input logic [MAG_W-1:0] mag);
        band_heights_t  batch [$];
        band_heights_t  r;
        logic [H_W-1:0] level;
        logic [H_W-1:0] bar;
        logic [H_W-1:0] peak;
        logic [31:0]    prod;
        int             lo;
        int             hi;
        int             k;
        bit             done;
        if (func == FUNC_CLEAR) begin
            for (k = 0; k < BAND_COUNT; k++) begin
                bar_mem[k]  = '0;
                peak_mem[k] = '0;
            end
        end else begin
            done = 1'b0;
            while (!done && batch.size() < MAX_RESULTS) begin
                lo = band_first_bin(open_band);
                hi = band_final_bin(open_band);
                if (int'(bin) < lo) begin
                    done = 1'b1;
                end else begin
                    // only a bin inside the band counts toward its maximum
                    if (int'(bin) <= hi && mag > band_max) band_max = mag;
                    if (int'(bin) < hi) begin
                        done = 1'b1;
                    end else begin
                        level = log_height(64'(gain_q) * 64'(band_max));
                        if (level > bar_mem[open_band]) begin
                            bar = level;
                        end else begin
                            prod = 32'(bar_mem[open_band]) * 32'(bar_decay_q);
                            bar  = prod[31:16];
                        end
                        if (bar > peak_mem[open_band]) begin
                            peak = bar;
                        end else begin
                            prod = 32'(peak_mem[open_band]) * 32'(peak_decay_q);
                            peak = prod[31:16];
                        end
                        bar_mem[open_band]  = bar;
                        peak_mem[open_band] = peak;
                        r.band = BAND_W'(open_band);
                        r.bar  = bar;
                        r.peak = peak;
                        r.last = 1'b0;
                        batch.push_back(r);
                        band_max = '0;
                        if (open_band == BAND_COUNT - 1) begin
                            open_band = 0;
                            done      = 1'b1;
                        end else begin
                            open_band++;
                        end
                    end
                end
            end
            for (k = 0; k < batch.size(); k++) begin
                r      = batch[k];
                r.last = (k == batch.size() - 1);
                heights_due.push_back(r);
            end
        end
    endtask

    task automatic match_heights();
        band_heights_t want;
        if (heights_due.size() == 0) begin
            report_mismatch($sformatf("unexpected band %0d bar %0d peak %0d last %0b",
                                      m_band, m_bar_height, m_peak_height, m_last));
        end else begin
            want = heights_due.pop_front();
            if (m_band !== want.band || m_bar_height !== want.bar ||
                m_peak_height !== want.peak || m_last !== want.last) begin
                report_mismatch($sformatf(
                    "band %0d bar %0d peak %0d last %0b, wanted band %0d bar %0d peak %0d last %0b",
                    m_band, m_bar_height, m_peak_height, m_last,
                    want.band, want.bar, want.peak, want.last));
            end
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < BAND_COUNT; k++) begin
                bar_mem[k]  = '0;
                peak_mem[k] = '0;
            end
            band_max     = '0;
            open_band    = 0;
            gain_q       = GAIN_RST;
            bar_decay_q  = BAR_DECAY_RST;
            peak_decay_q = PEAK_DECAY_RST;
            heights_due.delete();
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    CFG_GAIN:       gain_q       = cfg_data[GAIN_W-1:0];
                    CFG_BAR_DECAY:  bar_decay_q  = cfg_data[H_W-1:0];
                    CFG_PEAK_DECAY: peak_decay_q = cfg_data[H_W-1:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready) advance_bands(s_func, s_bin, s_magnitude);
            if (m_valid && m_ready) match_heights();
        end
        due_count = heights_due.size();
    end

endmodule

// ===== tb/log_band_peak_hold_bars_tb.sv =====
// ----------------------------------------------------------------------------
// log_band_peak_hold_bars_tb
// drives fft bin sweeps, clears and register settings into the log band bar
// engine with random idling on both channels; a checker beside the block
// predicts every band result and counts mismatches
// ----------------------------------------------------------------------------
module log_band_peak_hold_bars_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lbph_pkg::*;

    localparam int HALF_PERIOD   = 4;
    localparam int RESET_CYCLES  = 11;
    // a bin with no band to finish only passes the check, each band it finishes
    // adds a run of the band steps
    localparam int SETTLE_CYCLES = 64;
    localparam int IDLE_PCT      = 8;
    localparam int HOLD_CYCLES   = 3000;
    localparam int QUIET_CYCLES  = 2000;
    localparam int PHASES        = 6;
    localparam int LIMIT_NS      = 5_000_000;
    localparam logic [MAG_W-1:0] MAG_MAX = {MAG_W{1'b1}};

    logic              aclk          = 1'b0;
    logic              aresetn       = 1'b0;
    logic              s_valid       = 1'b0;
    logic              s_ready;
    logic              s_func        = FUNC_BIN;
    logic [BIN_W-1:0]  s_bin         = '0;
    logic [MAG_W-1:0]  s_magnitude   = '0;
    logic              m_valid;
    logic              m_ready       = 1'b0;
    logic [BAND_W-1:0] m_band;
    logic [H_W-1:0]    m_bar_height;
    logic [H_W-1:0]    m_peak_height;
    logic              m_last;
    logic              cfg_we        = 1'b0;
    logic [CIDX_W-1:0] cfg_index     = CFG_GAIN;
    logic [CFG_W-1:0]  cfg_data      = '0;

    int                mismatch_count;
    int                pending_count;

    // stimulus controls shared between processes
    bit                gaps_on    = 1'b1;
    bit                hold_req   = 1'b0;
    bit                hold_done  = 1'b0;
    logic [GAIN_W-1:0] cur_gain   = GAIN_RST;
    int                phase_sent = 0;

    always #(HALF_PERIOD) aclk = ~aclk;

    log_band_peak_hold_bars i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_func        (s_func),
        .s_bin         (s_bin),
        .s_magnitude   (s_magnitude),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_band        (m_band),
        .m_bar_height  (m_bar_height),
        .m_peak_height (m_peak_height),
        .m_last        (m_last),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    lbph_band_checker i_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_func         (s_func),
        .s_bin          (s_bin),
        .s_magnitude    (s_magnitude),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_band         (m_band),
        .m_bar_height   (m_bar_height),
        .m_peak_height  (m_peak_height),
        .m_last         (m_last),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mismatch_count (mismatch_count),
        .pending_count  (pending_count)
    );

    // magnitudes mostly below the point where the log saturates for the
    // current gain, so bars and peaks actually move and decay
    function automatic logic [MAG_W-1:0] pick_magnitude();
        int lim;
        lim = (cur_gain == '0) ? 65535 : 65535 / int'(cur_gain);
        case ($urandom_range(0, 5))
            0:       return MAG_W'($urandom_range(0, int'(MAG_MAX)));
            1:       return '0;
            2:       return MAG_MAX;
            3, 4:    return MAG_W'($urandom_range(0, lim));
            default: return MAG_W'($urandom_range(0, 4095));
        endcase
    endfunction

    // one input transaction; called at a falling edge, returns at the falling
    // edge after acceptance with valid still high so the next item can follow
    // back to back
    task automatic offer(input logic func, input logic [BIN_W-1:0] bin,
                         input logic [MAG_W-1:0] mag);
        while (gaps_on && $urandom_range(0, 99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid     <= 1'b1;
        s_func      <= func;
        s_bin       <= bin;
        s_magnitude <= mag;
        @(posedge aclk);
        while (s_ready !== 1'b1) @(posedge aclk);
        @(negedge aclk);
    endtask

    // register write, one per cycle; the caller lowers the enable
    task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge aclk);
    endtask

    // drop valid, wait for every predicted band result, then let a bin that
    // finishes no band work its way through
    task automatic wait_quiet();
        s_valid <= 1'b0;
        while (pending_count != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // result side: random ready, one long hold-off on request so the block
    // backs up into its input, then a long stretch of ready held high
    initial begin : result_sink
        int k;
        int quiet_left;
        quiet_left = 0;
        wait (aresetn === 1'b1);
        forever begin
            @(negedge aclk);
            if (hold_req && !hold_done) begin
                hold_done = 1'b1;
                m_ready <= 1'b0;
                for (k = 0; k < HOLD_CYCLES; k++) @(negedge aclk);
                quiet_left = QUIET_CYCLES;
            end else if (quiet_left > 0) begin
                quiet_left--;
                m_ready <= 1'b1;
            end else begin
                m_ready <= ($urandom_range(0, 99) >= IDLE_PCT);
            end
        end
    end

    initial begin : stimulus
        int                ph;
        int                b;
        int                density;
        int                stop_bin;
        int                budget;
        logic [GAIN_W-1:0] g;
        logic [H_W-1:0]    bd;
        logic [H_W-1:0]    pd;

        repeat (RESET_CYCLES) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed part at the reset register values
        // clear with nothing stored yet
        offer(FUNC_CLEAR, 7'h55, 23'h2AAAAA);
        // bin 0 sits below the first band and is dropped
        offer(FUNC_BIN, 7'd0, MAG_MAX);
        // bin 1 closes the four one-bin bands at full scale
        offer(FUNC_BIN, 7'd1, MAG_MAX);
        // bin 2 closes the band shared with bin 1, then two silent bands
        offer(FUNC_BIN, 7'd2, '0);
        // just below log saturation at gain 120
        offer(FUNC_BIN, 7'd3, 23'd500);
        // bin below the open band is dropped
        offer(FUNC_BIN, 7'd1, MAG_MAX);
        // jump to the top bin: eight bands per transaction, rest left pending
        offer(FUNC_BIN, 7'd127, 23'd1);
        offer(FUNC_BIN, 7'd127, 23'd1);
        // closes the last band, frame wraps to band 0
        offer(FUNC_BIN, 7'd127, 23'd1);
        // empty bands in the new frame: bars and peaks decay
        offer(FUNC_BIN, 7'd127, MAG_MAX);
        offer(FUNC_BIN, 7'd127, MAG_MAX);
        // clear in the middle of a frame keeps the open band
        offer(FUNC_CLEAR, 7'h2A, 23'h555555);
        offer(FUNC_BIN, 7'd127, '0);
        offer(FUNC_BIN, 7'd127, '0);
        // smallest nonzero magnitude
        offer(FUNC_BIN, 7'd1, 23'd1);
        // repeated bin inside the open band raises its maximum
        offer(FUNC_BIN, 7'd1, 23'd546);
        offer(FUNC_BIN, 7'd2, 23'd547);
        offer(FUNC_BIN, 7'd126, 23'h400000);
        wait_quiet();

        // random part: each phase gets its own register setting, written
        // only once the block has gone quiet
        for (ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: begin
                    g = '1;  bd = '1;  pd = '1;  budget = 70;
                end
                1: begin
                    g = GAIN_W'(1);  bd = '0;  pd = '0;  budget = 60;
                end
                2: begin
                    // zero gain: every band level is zero, only decay moves
                    g = '0;  bd = H_W'($urandom());  pd = H_W'($urandom());  budget = 30;
                end
                5: begin
                    g = GAIN_RST;  bd = BAR_DECAY_RST;  pd = PEAK_DECAY_RST;  budget = 50;
                end
                default: begin
                    g  = GAIN_W'($urandom_range(1, 1023));
                    bd = H_W'($urandom());
                    pd = H_W'($urandom());
                    budget = 50;
                end
            endcase
            cur_gain = g;
            write_reg(CFG_GAIN, CFG_W'(g));
            write_reg(CFG_BAR_DECAY, bd);
            write_reg(CFG_PEAK_DECAY, pd);
            cfg_we <= 1'b0;

            // second phase runs with no idle cycles on the input side
            gaps_on = (ph != 1);
            // first phase: the result side stalls while bins keep coming
            if (ph == 0) hold_req = 1'b1;

            phase_sent = 0;
            while (phase_sent < budget) begin
                // sparse sweeps skip bins and finish several bands at once;
                // some sweeps are cut short and the next one restarts low
                density  = $urandom_range(5, 60);
                stop_bin = ($urandom_range(0, 9) == 0) ?
                           $urandom_range(2, BIN_COUNT - 2) : BIN_COUNT - 1;
                for (b = 1; b <= stop_bin && phase_sent < budget; b++) begin
                    if (b == BIN_COUNT - 1 || $urandom_range(0, 99) < density) begin
                        offer(FUNC_BIN, BIN_W'(b), pick_magnitude());
                        phase_sent++;
                    end
                    if ($urandom_range(0, 99) == 0) begin
                        offer(FUNC_CLEAR, BIN_W'($urandom()), MAG_W'($urandom()));
                        phase_sent++;
                    end
                    // stray bin out of order, mostly dropped by the block
                    if ($urandom_range(0, 149) == 0) begin
                        offer(FUNC_BIN, BIN_W'($urandom()), MAG_W'($urandom()));
                    end
                end
            end
            wait_quiet();
        end

        if (mismatch_count == 0 && pending_count == 0) begin
            $display("log_band_peak_hold_bars_tb: PASS");
        end else begin
            $display("log_band_peak_hold_bars_tb: FAIL");
        end
        $finish;
    end

    // watchdog far above the slowest correct run
    initial begin : watchdog
        #(LIMIT_NS);
        $display("log_band_peak_hold_bars_tb: FAIL");
        $finish;
    end

endmodule
